[src/chw_pkg.sv]
// chw_pkg: widths, operation and register codes, and transfer types for the
// coefficient histogram window. No dependencies; imported by every module.
package chw_pkg;

    localparam int COEF_BITS    = 12;
    localparam int COUNT_BITS   = 32;
    localparam int BIN_DEPTH    = 1 << COEF_BITS;
    localparam int CFG_IDX_BITS = 2;

    // operation codes
    localparam logic [1:0] OP_ADD   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_LOWER = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_UPPER = CFG_IDX_BITS'(1);

    // bound reset values: full signed range
    localparam logic signed [COEF_BITS-1:0] LOWER_RESET = {1'b1, {(COEF_BITS-1){1'b0}}};
    localparam logic signed [COEF_BITS-1:0] UPPER_RESET = {1'b0, {(COEF_BITS-1){1'b1}}};

    typedef struct packed {
        logic [1:0]                   operation;
        logic signed [COEF_BITS-1:0]  coefficient;
    } item_t;

    typedef struct packed {
        logic signed [COEF_BITS-1:0]  bin_value;
        logic [COUNT_BITS-1:0]        bin_count;
        logic                         last_bin;
        logic                         window_empty;
    } result_t;

    // request handed from the control stage to the bin store
    typedef struct packed {
        logic                  valid;
        logic                  is_read;
        logic                  empty;
        logic                  last;
        logic [COEF_BITS-1:0]  index;
    } bin_req_t;

endpackage

[src/chw_ctrl.sv]
// chw_ctrl: bound registers, observed extremes and read cursor; decodes each
// accepted item into a bin store request. Depends on chw_pkg.
module chw_ctrl
    import chw_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  item_t                   item,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [COEF_BITS-1:0]    cfg_data,
    output bin_req_t                req,
    output logic                    clear_start
);

    logic signed [COEF_BITS-1:0] lower_reg, lower_next;
    logic signed [COEF_BITS-1:0] upper_reg, upper_next;
    logic signed [COEF_BITS-1:0] min_reg, min_next;
    logic signed [COEF_BITS-1:0] max_reg, max_next;
    logic signed [COEF_BITS-1:0] cursor_reg, cursor_next;
    logic                        reading_reg, reading_next;

    logic signed [COEF_BITS-1:0] lo;
    logic signed [COEF_BITS-1:0] hi;
    logic signed [COEF_BITS-1:0] cur;
    logic                        empty;
    logic                        last;

    // window: observed range cut to the bounds
    always_comb
    begin
        lo    = (min_reg > lower_reg) ? min_reg : lower_reg;
        hi    = (max_reg < upper_reg) ? max_reg : upper_reg;
        empty = lo > hi;
        cur   = (!reading_reg || cursor_reg < lo || cursor_reg > hi) ? lo : cursor_reg;
        last  = cur == hi;
    end

    // request for the bin store
    always_comb
    begin
        req         = '0;
        clear_start = 1'b0;
        case (item.operation)
            OP_ADD:
            begin
                req.valid = 1'b1;
                req.index = item.coefficient;
            end
            OP_READ:
            begin
                req.valid   = 1'b1;
                req.is_read = 1'b1;
                req.empty   = empty;
                req.last    = empty | last;
                req.index   = empty ? '0 : cur;
            end
            OP_CLEAR:
            begin
                clear_start = accept;
            end
            default:
            begin
                req = '0;
            end
        endcase
    end

    // configuration writes and state update
    always_comb
    begin
        lower_next   = lower_reg;
        upper_next   = upper_reg;
        min_next     = min_reg;
        max_next     = max_reg;
        cursor_next  = cursor_reg;
        reading_next = reading_reg;

        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == REG_LOWER)
            begin
                lower_next = cfg_data;
            end
            else if (cfg_index == REG_UPPER)
            begin
                upper_next = cfg_data;
            end
        end

        if (accept)
        begin
            case (item.operation)
                OP_ADD:
                begin
                    if (item.coefficient < min_reg)
                    begin
                        min_next = item.coefficient;
                    end
                    if (item.coefficient > max_reg)
                    begin
                        max_next = item.coefficient;
                    end
                    reading_next = 1'b0;
                end
                OP_READ:
                begin
                    if (empty)
                    begin
                        reading_next = 1'b0;
                    end
                    else if (last)
                    begin
                        cursor_next  = cur;
                        reading_next = 1'b0;
                    end
                    else
                    begin
                        cursor_next  = cur + 1'b1;
                        reading_next = 1'b1;
                    end
                end
                OP_CLEAR:
                begin
                    min_next     = '0;
                    max_next     = '0;
                    cursor_next  = '0;
                    reading_next = 1'b0;
                end
                default:
                begin
                    reading_next = reading_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lower_reg   <= LOWER_RESET;
            upper_reg   <= UPPER_RESET;
            min_reg     <= '0;
            max_reg     <= '0;
            cursor_reg  <= '0;
            reading_reg <= 1'b0;
        end
        else
        begin
            lower_reg   <= lower_next;
            upper_reg   <= upper_next;
            min_reg     <= min_next;
            max_reg     <= max_next;
            cursor_reg  <= cursor_next;
            reading_reg <= reading_next;
        end
    end

endmodule

[src/chw_bins.sv]
// chw_bins: bin count memory with read-modify-write stage, write forwarding
// and the clearing sweep. Depends on chw_pkg.
module chw_bins
    import chw_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      accept,
    input  bin_req_t  req,
    input  logic      clear_start,
    input  logic      out_free,
    output logic      advance,
    output logic      busy,
    output logic      res_valid,
    output result_t   res
);

    logic [COUNT_BITS-1:0] mem [BIN_DEPTH];

    bin_req_t              s2_reg, s2_next;
    logic [COUNT_BITS-1:0] rdata_reg;
    logic                  fwd_valid_reg, fwd_valid_next;
    logic [COEF_BITS-1:0]  fwd_idx_reg;
    logic [COUNT_BITS-1:0] fwd_data_reg;
    logic                  sweep_reg, sweep_next;
    logic [COEF_BITS-1:0]  sweep_idx_reg, sweep_idx_next;

    logic [COUNT_BITS-1:0] cur_count;
    logic [COUNT_BITS-1:0] inc_count;
    logic                  wr_en;
    logic [COEF_BITS-1:0]  wr_idx;
    logic [COUNT_BITS-1:0] wr_data;

    // current count, taking the latest write where the memory is behind
    always_comb
    begin
        cur_count = (fwd_valid_reg && fwd_idx_reg == s2_reg.index) ? fwd_data_reg : rdata_reg;
        inc_count = (cur_count == {COUNT_BITS{1'b1}}) ? cur_count : cur_count + 1'b1;
    end

    // stage two moves on unless a result waits for the output register
    assign advance   = !s2_reg.valid || !s2_reg.is_read || out_free;
    assign busy      = sweep_reg;
    assign res_valid = s2_reg.valid && s2_reg.is_read;

    always_comb
    begin
        res.bin_value    = s2_reg.empty ? '0 : $signed(s2_reg.index);
        res.bin_count    = s2_reg.empty ? '0 : cur_count;
        res.last_bin     = s2_reg.last;
        res.window_empty = s2_reg.empty;
    end

    // write port: sweep or incremented count
    always_comb
    begin
        if (sweep_reg)
        begin
            wr_en   = 1'b1;
            wr_idx  = sweep_idx_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = s2_reg.valid && !s2_reg.is_read;
            wr_idx  = s2_reg.index;
            wr_data = inc_count;
        end
    end

    // stage and sweep control
    always_comb
    begin
        s2_next        = s2_reg;
        sweep_next     = sweep_reg;
        sweep_idx_next = sweep_idx_reg;
        fwd_valid_next = fwd_valid_reg;

        if (accept)
        begin
            s2_next = req;
        end
        else if (advance)
        begin
            s2_next.valid = 1'b0;
        end

        if (clear_start)
        begin
            sweep_next     = 1'b1;
            sweep_idx_next = '0;
        end
        else if (sweep_reg)
        begin
            sweep_idx_next = sweep_idx_reg + 1'b1;
            if (sweep_idx_reg == {COEF_BITS{1'b1}})
            begin
                sweep_next = 1'b0;
            end
        end

        if (sweep_reg)
        begin
            fwd_valid_next = 1'b0;
        end
        else if (wr_en)
        begin
            fwd_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg        <= '0;
            sweep_reg     <= 1'b1;
            sweep_idx_reg <= '0;
            fwd_valid_reg <= 1'b0;
        end
        else
        begin
            s2_reg        <= s2_next;
            sweep_reg     <= sweep_next;
            sweep_idx_reg <= sweep_idx_next;
            fwd_valid_reg <= fwd_valid_next;
        end
    end

    // forwarding copy of the latest count write
    always_ff @(posedge clk)
    begin
        if (wr_en && !sweep_reg)
        begin
            fwd_idx_reg  <= wr_idx;
            fwd_data_reg <= wr_data;
        end
    end

    // bin memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (accept && req.valid && !req.empty)
        begin
            rdata_reg <= mem[req.index];
        end
    end

endmodule

[src/coefficient_histogram_window.sv]
// coefficient_histogram_window: top level joining control, bin store and the
// result register. Depends on chw_pkg, chw_ctrl and chw_bins.
//
//  channel  | signals                                | carries
//  ---------+----------------------------------------+-----------------------------
//  item     | item_valid, item_ready, item           | operation and coefficient
//  result   | result_valid, result_ready, result     | bin value, count, flags
//  cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data | bound register writes
//
// One item per cycle when item_ready is high: add and read items pass a two-stage
// read-modify-write on the bin memory (one read and one write port), with a
// forwarding register for repeated bins. A read result passes stage two and the
// result register. After reset and after every clear item the memory is swept to
// zero, one bin a cycle, while item_ready is low; cfg writes are always taken. A
// result held by result_ready low stalls the item channel once stage two is full.
module coefficient_histogram_window
    import chw_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    item_valid,
    output logic                    item_ready,
    input  item_t                   item,
    output logic                    result_valid,
    input  logic                    result_ready,
    output result_t                 result,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [COEF_BITS-1:0]    cfg_data
);

    bin_req_t req;
    logic     clear_start;
    logic     accept;
    logic     advance;
    logic     busy;
    logic     out_free;
    logic     res_valid;
    result_t  res;

    logic     result_valid_reg, result_valid_next;
    result_t  result_reg;

    assign cfg_ready    = 1'b1;
    assign item_ready   = !busy && advance;
    assign accept       = item_valid && item_ready;
    assign out_free     = !result_valid_reg || result_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    chw_ctrl u_ctrl
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .item        (item),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .req         (req),
        .clear_start (clear_start)
    );

    chw_bins u_bins
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .req         (req),
        .clear_start (clear_start),
        .out_free    (out_free),
        .advance     (advance),
        .busy        (busy),
        .res_valid   (res_valid),
        .res         (res)
    );

    // result register
    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (res_valid && out_free)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && out_free)
        begin
            result_reg <= res;
        end
    end

endmodule

[src/chw_checker.sv]
// chw_checker: port-level checks for the coefficient histogram window and the
// bind that attaches them. Depends on chw_pkg and coefficient_histogram_window.
module chw_checker
    import chw_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    item_valid,
    input logic                    item_ready,
    input item_t                   item,
    input logic                    result_valid,
    input logic                    result_ready,
    input result_t                 result
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // empty window reports a final zero bin
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.window_empty |->
            result.last_bin && result.bin_count == '0 && result.bin_value == '0)
        else $error("empty window result malformed");

    // a clear transfer starts the sweep
    assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && item.operation == OP_CLEAR |=> !item_ready)
        else $error("item taken during clearing sweep");

    // add, clear and ignored transfers never raise a result on their own; a read
    // taken in the cycle before may still be leaving stage two
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid && item_valid && item_ready && item.operation != OP_READ
            && !$past(item_valid && item_ready && item.operation == OP_READ)
            |=> !result_valid)
        else $error("result without a read");

endmodule

bind coefficient_histogram_window chw_checker u_chk (.*);

[test/tb_coefficient_histogram_window.sv]
`timescale 1ns / 1ps
// tb_coefficient_histogram_window: self-checking bench for the coefficient histogram window.
// Depends on chw_pkg and coefficient_histogram_window; a directed table runs first, then
// random phases under bursty input and a stalling result sink, checked against the table or a model.
module tb_coefficient_histogram_window;
    import chw_pkg::*;

    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int RANDOM_ITEMS   = 1700;
    localparam int MAX_CLEARS     = 40;
    localparam int SETTLE_CYCLES  = 4;
    localparam int HOLDOFF_AFTER  = 250;
    localparam int HOLDOFF_CYCLES = 500;
    localparam int PRINT_LIMIT    = 100;

    // operation code the block ignores, and register indexes past the list
    localparam logic [1:0]              OP_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE0 = CFG_IDX_BITS'(2);
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE1 = CFG_IDX_BITS'(3);

    typedef enum logic [1:0] {ROW_ITEM, ROW_TYPED, ROW_REG} row_kind_e;
    typedef enum logic [1:0] {SINK_OPEN, SINK_HALF, SINK_SPARSE, SINK_MOSTLY} sink_mode_e;

    typedef struct packed {
        row_kind_e                  kind;
        item_t                      it;
        logic [CFG_IDX_BITS-1:0]    reg_idx;
        logic [COEF_BITS-1:0]       reg_val;
        result_t                    exp;
    } row_t;

    logic                    clk;
    logic                    rst_n        = 1'b0;
    logic                    item_valid   = 1'b0;
    logic                    item_ready;
    item_t                   item         = '0;
    logic                    result_valid;
    logic                    result_ready = 1'b0;
    result_t                 result;
    logic                    cfg_valid    = 1'b0;
    logic                    cfg_ready;
    logic [CFG_IDX_BITS-1:0] cfg_index    = '0;
    logic [COEF_BITS-1:0]    cfg_data     = '0;

    // histogram model state
    logic [COUNT_BITS-1:0] bin_tally [BIN_DEPTH];
    int                    seen_min;
    int                    seen_max;
    int                    walk_pos;
    bit                    walking;
    int                    win_lower;
    int                    win_upper;

    result_t pending_bins [$];
    row_t    dir_rows [$];

    int cycle_count   = 0;
    int fail_count    = 0;
    int results_seen  = 0;
    int window_ends   = 0;
    int empty_windows = 0;
    int adds_sent     = 0;
    int reads_sent    = 0;
    int clears_sent   = 0;
    int reg_writes    = 0;
    int burst_left    = 0;
    bit holdoff_done  = 1'b0;

    coefficient_histogram_window i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // watchdog
    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    task automatic report_fail(input string msg);
        fail_count++;
        if (fail_count <= PRINT_LIMIT)
            $display("mismatch %0d at cycle %0d: %s", fail_count, cycle_count, msg);
    endtask

    // model: one item in, at most one bin report out
    function automatic bit histogram_step(input item_t it, output result_t res);
        int                   lo;
        int                   hi;
        logic [COEF_BITS-1:0] k;
        res = '0;
        k   = it.coefficient;
        case (it.operation)
            OP_ADD:
            begin
                if (bin_tally[k] != '1)
                    bin_tally[k] = bin_tally[k] + 1'b1;
                if (int'(it.coefficient) < seen_min)
                    seen_min = int'(it.coefficient);
                if (int'(it.coefficient) > seen_max)
                    seen_max = int'(it.coefficient);
                walking = 1'b0;
                return 1'b0;
            end
            OP_CLEAR:
            begin
                foreach (bin_tally[j])
                    bin_tally[j] = '0;
                seen_min = 0;
                seen_max = 0;
                walk_pos = 0;
                walking  = 1'b0;
                return 1'b0;
            end
            OP_READ:
            begin
                lo = (seen_min > win_lower) ? seen_min : win_lower;
                hi = (seen_max < win_upper) ? seen_max : win_upper;
                // window cut away entirely
                if (lo > hi)
                begin
                    walking          = 1'b0;
                    res.last_bin     = 1'b1;
                    res.window_empty = 1'b1;
                    return 1'b1;
                end
                // restart after a finished walk, an add, or a moved window
                if (!walking || walk_pos < lo || walk_pos > hi)
                begin
                    walk_pos = lo;
                    walking  = 1'b1;
                end
                res.bin_value = walk_pos[COEF_BITS-1:0];
                res.bin_count = bin_tally[walk_pos[COEF_BITS-1:0]];
                if (walk_pos == hi)
                begin
                    res.last_bin = 1'b1;
                    walking      = 1'b0;
                end
                else
                    walk_pos++;
                return 1'b1;
            end
            default:
                return 1'b0;
        endcase
    endfunction

    // wait until every bin report is in and the pipeline has drained
    task automatic settle();
        item_valid <= 1'b0;
        burst_left = 0;
        while (pending_bins.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [COEF_BITS-1:0] val);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_LOWER)
            win_lower = int'($signed(val));
        else if (idx == REG_UPPER)
            win_upper = int'($signed(val));
        reg_writes++;
    endtask

    // offer one item, with random gaps between bursts
    task automatic push_item(input item_t it, input bit typed, input result_t typed_res);
        result_t res;
        bit      has_res;
        if (burst_left == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        item_valid <= 1'b1;
        item       <= it;
        do @(posedge clk); while (!item_ready);
        has_res = histogram_step(it, res);
        if (has_res)
            pending_bins.push_back(typed ? typed_res : res);
        case (it.operation)
            OP_ADD:   adds_sent++;
            OP_READ:  reads_sent++;
            OP_CLEAR: clears_sent++;
            default:  ;
        endcase
    endtask

    function automatic row_t op_row(input logic [1:0] op, input int coef);
        row_t r;
        r                = '0;
        r.kind           = ROW_ITEM;
        r.it.operation   = op;
        r.it.coefficient = coef[COEF_BITS-1:0];
        return r;
    endfunction

    function automatic row_t read_row(input int value, input int count,
                                      input bit last, input bit empty);
        row_t r;
        r                  = '0;
        r.kind             = ROW_TYPED;
        r.it.operation     = OP_READ;
        r.it.coefficient   = value[COEF_BITS-1:0];
        r.exp.bin_value    = value[COEF_BITS-1:0];
        r.exp.bin_count    = count;
        r.exp.last_bin     = last;
        r.exp.window_empty = empty;
        return r;
    endfunction

    function automatic row_t reg_row(input logic [CFG_IDX_BITS-1:0] idx, input int val);
        row_t r;
        r         = '0;
        r.kind    = ROW_REG;
        r.reg_idx = idx;
        r.reg_val = val[COEF_BITS-1:0];
        return r;
    endfunction

    // coefficients mostly near zero, some at the bounds, a few anywhere
    function automatic logic [COEF_BITS-1:0] pick_coef();
        int sel;
        int v;
        sel = $urandom_range(0, 99);
        if (sel < 80)
            v = int'($urandom_range(0, 16)) - 8;
        else if (sel < 92)
            v = (sel[0] ? win_lower : win_upper) + int'($urandom_range(0, 4)) - 2;
        else
            v = $urandom;
        return v[COEF_BITS-1:0];
    endfunction

    // result check against the oldest expected bin report
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            results_seen++;
            if (result.last_bin)
                window_ends++;
            if (result.window_empty)
                empty_windows++;
            if (pending_bins.size() == 0)
                report_fail($sformatf("unexpected result %p", result));
            else
            begin
                want = pending_bins.pop_front();
                if (result.bin_value !== want.bin_value)
                    report_fail($sformatf("bin_value got %0d want %0d",
                                          result.bin_value, want.bin_value));
                if (result.bin_count !== want.bin_count)
                    report_fail($sformatf("bin_count got %0d want %0d at value %0d",
                                          result.bin_count, want.bin_count, want.bin_value));
                if (result.last_bin !== want.last_bin)
                    report_fail($sformatf("last_bin got %b want %b at value %0d",
                                          result.last_bin, want.last_bin, want.bin_value));
                if (result.window_empty !== want.window_empty)
                    report_fail($sformatf("window_empty got %b want %b",
                                          result.window_empty, want.window_empty));
            end
        end
    end

    // result sink: stall pattern in segments, plus one long hold-off while items are offered
    initial
    begin : sink_pattern
        sink_mode_e mode;
        int         seg_left;
        int         hold_count;
        mode     = SINK_OPEN;
        seg_left = 0;
        forever
        begin
            @(posedge clk);
            if (!holdoff_done && results_seen >= HOLDOFF_AFTER && item_valid)
            begin
                result_ready <= 1'b0;
                hold_count = 0;
                while (hold_count < HOLDOFF_CYCLES)
                begin
                    @(posedge clk);
                    hold_count++;
                end
                holdoff_done = 1'b1;
            end
            if (seg_left == 0)
            begin
                mode     = sink_mode_e'($urandom_range(0, 3));
                seg_left = $urandom_range(20, 200);
            end
            seg_left--;
            case (mode)
                SINK_OPEN:   result_ready <= 1'b1;
                SINK_HALF:   result_ready <= ($urandom_range(0, 1) == 1);
                SINK_SPARSE: result_ready <= ($urandom_range(0, 3) == 0);
                default:     result_ready <= ($urandom_range(0, 7) != 0);
            endcase
        end
    end

    // stimulus
    initial
    begin : stimulus
        item_t   it;
        result_t none;
        int      lo;
        int      hi;
        int      read_pct;
        int      phase_len;
        int      sel;
        int      clears_left;
        int      random_items;

        none         = '0;
        clears_left  = MAX_CLEARS;
        random_items = 0;

        // model reset
        foreach (bin_tally[j])
            bin_tally[j] = '0;
        seen_min  = 0;
        seen_max  = 0;
        walk_pos  = 0;
        walking   = 1'b0;
        win_lower = int'(LOWER_RESET);
        win_upper = int'(UPPER_RESET);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed table
        dir_rows.push_back(read_row(0, 0, 1'b1, 1'b0));          // window is just zero
        dir_rows.push_back(op_row(OP_ADD, 0));
        dir_rows.push_back(op_row(OP_ADD, 0));
        dir_rows.push_back(read_row(0, 2, 1'b1, 1'b0));
        dir_rows.push_back(op_row(OP_ADD, -2048));
        dir_rows.push_back(op_row(OP_ADD, 2047));
        dir_rows.push_back(op_row(OP_UNUSED, -1));               // ignored
        dir_rows.push_back(reg_row(REG_LOWER, 2046));
        dir_rows.push_back(read_row(2046, 0, 1'b0, 1'b0));
        dir_rows.push_back(read_row(2047, 1, 1'b1, 1'b0));
        dir_rows.push_back(reg_row(REG_UPPER, -2048));           // bounds crossed
        dir_rows.push_back(read_row(0, 0, 1'b1, 1'b1));
        dir_rows.push_back(reg_row(REG_LOWER, -2048));
        dir_rows.push_back(read_row(-2048, 1, 1'b1, 1'b0));
        dir_rows.push_back(reg_row(REG_SPARE0, 2047));           // index past the list
        dir_rows.push_back(reg_row(REG_LOWER, -1));
        dir_rows.push_back(reg_row(REG_UPPER, 1));
        dir_rows.push_back(op_row(OP_ADD, -1));
        dir_rows.push_back(op_row(OP_READ, 0));
        dir_rows.push_back(op_row(OP_ADD, 1));                   // add mid-walk
        dir_rows.push_back(op_row(OP_READ, 0));
        dir_rows.push_back(op_row(OP_READ, 0));
        dir_rows.push_back(reg_row(REG_UPPER, 0));               // window moves off cursor
        dir_rows.push_back(op_row(OP_READ, 0));
        dir_rows.push_back(op_row(OP_READ, 0));
        dir_rows.push_back(op_row(OP_CLEAR, 2047));
        dir_rows.push_back(read_row(0, 0, 1'b1, 1'b0));
        dir_rows.push_back(reg_row(REG_LOWER, 1));
        dir_rows.push_back(read_row(0, 0, 1'b1, 1'b1));
        dir_rows.push_back(reg_row(REG_LOWER, int'(LOWER_RESET)));
        dir_rows.push_back(reg_row(REG_UPPER, int'(UPPER_RESET)));

        foreach (dir_rows[i])
        begin
            case (dir_rows[i].kind)
                ROW_REG:   write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_val);
                ROW_TYPED: push_item(dir_rows[i].it, 1'b1, dir_rows[i].exp);
                default:   push_item(dir_rows[i].it, 1'b0, none);
            endcase
        end

        // random phases, each under its own window bounds
        while (random_items < RANDOM_ITEMS)
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    lo = int'(LOWER_RESET);
                    hi = int'(UPPER_RESET);
                end
                1:
                begin
                    lo = -int'($urandom_range(0, 8));
                    hi = $urandom_range(0, 8);
                end
                2:
                begin
                    lo = $urandom;
                    hi = $urandom;
                end
                3:
                begin
                    lo = $urandom_range(1, 2047);
                    hi = ($urandom_range(0, 1) == 0) ? lo - 1 : -int'($urandom_range(0, 2048));
                end
                4:
                begin
                    lo = ($urandom_range(0, 1) == 0) ? int'(LOWER_RESET) : int'(UPPER_RESET);
                    hi = ($urandom_range(0, 1) == 0) ? int'(LOWER_RESET) : int'(UPPER_RESET);
                end
                default:
                begin
                    lo = int'($urandom_range(0, 16)) - 8;
                    hi = lo + int'($urandom_range(0, 6));
                end
            endcase
            write_reg(REG_LOWER, lo[COEF_BITS-1:0]);
            write_reg(REG_UPPER, hi[COEF_BITS-1:0]);
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? REG_SPARE1 : REG_SPARE0,
                          COEF_BITS'($urandom));

            if (clears_left > 0 && $urandom_range(0, 2) == 0)
            begin
                it.operation   = OP_CLEAR;
                it.coefficient = COEF_BITS'($urandom);
                push_item(it, 1'b0, none);
                clears_left--;
                random_items++;
            end

            read_pct  = $urandom_range(25, 75);
            phase_len = $urandom_range(40, 120);
            if (phase_len > RANDOM_ITEMS - random_items)
                phase_len = RANDOM_ITEMS - random_items;
            repeat (phase_len)
            begin
                sel            = $urandom_range(0, 99);
                it.coefficient = pick_coef();
                if (sel < 2 && clears_left > 0)
                begin
                    it.operation = OP_CLEAR;
                    clears_left--;
                end
                else if (sel < 5)
                    it.operation = OP_UNUSED;
                else if (sel < 5 + read_pct)
                    it.operation = OP_READ;
                else
                    it.operation = OP_ADD;
                push_item(it, 1'b0, none);
                random_items++;
            end
        end

        // drain
        settle();

        $display("covered %0d adds, %0d reads, %0d clears and %0d register writes",
                 adds_sent, reads_sent, clears_sent, reg_writes);
        $display("%0d bin reports checked, %0d window ends, %0d empty windows, hold-off %s",
                 results_seen, window_ends, empty_windows, holdoff_done ? "done" : "missed");
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
